FILE: hdl/ccra_pkg.sv
// shared constants, table entry types and codes of the cache color reservation allocator
// depends on nothing
package ccra_pkg;

  localparam int NUM_COLORS      = 64;
  localparam int NUM_CACHES      = 4;
  localparam int BYTES_PER_COLOR = 65536;

  localparam int COLOR_W     = $clog2(NUM_COLORS);
  localparam int PTR_W       = $clog2(NUM_COLORS + 1);
  localparam int COLOR_SHIFT = $clog2(BYTES_PER_COLOR);
  localparam int BYTES_W     = 24;
  localparam int NCOL_W      = BYTES_W - COLOR_SHIFT + 1;
  localparam int PAGES_W     = 20;
  localparam int OWNER_W     = 22;
  localparam int REF_W       = 16;
  localparam int PCNT_W      = 32;
  localparam int OP_W        = 3;
  localparam int STATUS_W    = 2;
  localparam int MASK_W      = 64;

  // operation codes
  localparam logic [OP_W-1:0] OP_RES_SHARED  = 3'd0;
  localparam logic [OP_W-1:0] OP_RES_PRIVATE = 3'd1;
  localparam logic [OP_W-1:0] OP_RELEASE     = 3'd2;
  localparam logic [OP_W-1:0] OP_BUSY_ADD    = 3'd3;
  localparam logic [OP_W-1:0] OP_BUSY_REMOVE = 3'd4;
  localparam logic [OP_W-1:0] OP_SET_FREE    = 3'd5;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_SIZE  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NO_COLORS = 2'd2;

  // color types
  localparam logic [1:0] TYPE_FREE    = 2'd0;
  localparam logic [1:0] TYPE_SHARED  = 2'd1;
  localparam logic [1:0] TYPE_PRIVATE = 2'd2;

  typedef struct packed {
    logic [1:0]         ctype;
    logic [OWNER_W-1:0] owner;
    logic [REF_W-1:0]   refs;
  } slot_t;

  typedef slot_t [NUM_CACHES-1:0] slot_row_t;

  typedef struct packed {
    logic [PCNT_W-1:0] busy;
    logic [PCNT_W-1:0] free;
  } cnt_row_t;

  localparam int SLOT_ROW_W = $bits(slot_row_t);
  localparam int CNT_ROW_W  = $bits(cnt_row_t);

endpackage

FILE: hdl/cache_color_reservation_allocator.sv
// cache color reservation allocator: per cache and color type/owner/refcount table, per color
// busy and free page counts; no result stall; release makes one table pass, a reservation a
// classify pass, a pass per pick (one more when shared colors run out) and a commit pass; one
// item at a time: each pass walks the 64 rows of a table memory through its single read port;
// bad size or hopeless requests end at once; reset (async, low) clears control and the row valid
// bits, so counts, owners and refcounts read as zero without a clearing pass
module cache_color_reservation_allocator import ccra_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [OP_W-1:0]     operation_i,
  input  logic [3:0]          cache_mask_i,
  input  logic [BYTES_W-1:0]  region_bytes_i,
  input  logic [PAGES_W-1:0]  page_total_i,
  input  logic [MASK_W-1:0]   color_mask_i,
  input  logic [5:0]          color_index_i,
  input  logic [PAGES_W-1:0]  page_count_i,
  input  logic [OWNER_W-1:0]  owner_id_i,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic                cfg_data_i,
  output logic                done_o,
  output logic [STATUS_W-1:0] status_o,
  output logic [MASK_W-1:0]   region_mask_o
);

  // sequencer states
  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_CLASS   = 3'd1;  // classify every color for this cache mask
  localparam logic [2:0] S_DIVW    = 3'd2;  // wait for pages per color
  localparam logic [2:0] S_ROUND   = 3'd3;  // one pass finds the next lowest key color
  localparam logic [2:0] S_COMMIT  = 3'd4;  // write back claims for picked colors
  localparam logic [2:0] S_RELEASE = 3'd5;  // drop refcounts on released colors
  localparam logic [2:0] S_CNT     = 3'd6;  // busy or free count update

  logic [2:0]            state_q, state_d;
  logic                  use_free_q;
  logic                  priv_q, priv_d;
  logic [NUM_CACHES-1:0] cmask_q, cmask_d;
  logic [NUM_COLORS-1:0] color_mask_q, color_mask_d;
  logic [OP_W-1:0]       op_q, op_d;
  logic [COLOR_W-1:0]    cidx_q, cidx_d;
  logic [PAGES_W-1:0]    pcount_q, pcount_d;
  logic [OWNER_W-1:0]    owner_q, owner_d;
  logic [PTR_W-1:0]      ncol_q, ncol_d;

  // pass walker: read issued at ptr, evaluated in the next cycle at ev_idx
  logic [PTR_W-1:0]      ptr_q, ptr_d;
  logic                  ev_v_q, ev_v_d;
  logic [COLOR_W-1:0]    ev_idx_q, ev_idx_d;

  // candidate sets and picks
  logic [NUM_COLORS-1:0] exist_v_q, exist_v_d;
  logic [NUM_COLORS-1:0] fresh_v_q, fresh_v_d;
  logic [NUM_COLORS-1:0] picked_q, picked_d;
  logic [NUM_COLORS-1:0] pick_ex_q, pick_ex_d;
  logic [PTR_W-1:0]      got_q, got_d;
  logic                  phase_q, phase_d;  // 0 already shared colors, 1 new colors
  logic                  best_found_q, best_found_d;
  logic [PCNT_W-1:0]     best_key_q, best_key_d;
  logic [COLOR_W-1:0]    best_idx_q, best_idx_d;

  // result register
  logic                  done_q, done_d;
  logic [STATUS_W-1:0]   status_q, status_d;
  logic [MASK_W-1:0]     mask_q, mask_d;

  // memories
  slot_row_t             slot_rd, slot_wr;
  logic                  slot_we;
  cnt_row_t              cnt_rd, cnt_wr;
  logic                  cnt_we;
  logic [COLOR_W-1:0]    cnt_raddr;

  // divider
  logic                  div_start, div_done;
  logic [PAGES_W-1:0]    ppc;

  logic                  accept;
  logic                  issue, pass_end;
  logic [NCOL_W-1:0]     ncol_full;

  // per color evaluation
  logic                  all_shared, none_private, all_free;
  logic                  in_set, elig, better;
  logic [PCNT_W-1:0]     key;
  logic [PCNT_W:0]       busy_sum;

  assign accept      = start && !busy;
  assign busy        = state_q != S_IDLE;
  assign cfg_ready_o = 1'b1;
  assign issue       = ptr_q < PTR_W'(NUM_COLORS);
  assign pass_end    = !issue && !ev_v_q;

  // colors needed: size rounded up to whole colors
  assign ncol_full = NCOL_W'(region_bytes_i >> COLOR_SHIFT)
                   + NCOL_W'(|(region_bytes_i & BYTES_W'(BYTES_PER_COLOR - 1)));

  assign cnt_raddr = (state_q == S_IDLE) ? color_index_i[COLOR_W-1:0] : ptr_q[COLOR_W-1:0];

  ccra_ram #(
    .WIDTH  (SLOT_ROW_W),
    .ADDR_W (COLOR_W)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .raddr_i (ptr_q[COLOR_W-1:0]),
    .rdata_o (slot_rd),
    .we_i    (slot_we),
    .waddr_i (ev_idx_q),
    .wdata_i (slot_wr)
  );

  ccra_ram #(
    .WIDTH  (CNT_ROW_W),
    .ADDR_W (COLOR_W)
  ) u_cnt_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .raddr_i (cnt_raddr),
    .rdata_o (cnt_rd),
    .we_i    (cnt_we),
    .waddr_i (cidx_q),
    .wdata_i (cnt_wr)
  );

  ccra_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (page_total_i),
    .divisor_i  (ncol_full[PTR_W-1:0]),
    .done_o     (div_done),
    .quot_o     (ppc)
  );

  // type flags of the row under evaluation, over the requested caches
  always_comb begin
    all_shared   = 1'b1;
    none_private = 1'b1;
    all_free     = 1'b1;
    for (int c = 0; c < NUM_CACHES; c++) begin
      if (cmask_q[c]) begin
        if (slot_rd[c].ctype != TYPE_SHARED)  all_shared   = 1'b0;
        if (slot_rd[c].ctype == TYPE_PRIVATE) none_private = 1'b0;
        if (slot_rd[c].ctype != TYPE_FREE)    all_free     = 1'b0;
      end
    end
  end

  // ranking: ties keep the lower index because the walk is ascending and the compare strict
  always_comb begin
    in_set = phase_q ? fresh_v_q[ev_idx_q] : exist_v_q[ev_idx_q];
    key    = use_free_q ? cnt_rd.free : cnt_rd.busy;
    elig   = in_set && !picked_q[ev_idx_q]
          && (!use_free_q || (cnt_rd.free >= PCNT_W'(ppc)));
    better = elig && (!best_found_q || (key < best_key_q));
  end

  // row write-back for commit and release passes
  always_comb begin
    slot_wr = slot_rd;
    for (int c = 0; c < NUM_CACHES; c++) begin
      if (cmask_q[c]) begin
        if (state_q == S_RELEASE) begin
          if (slot_rd[c].refs <= REF_W'(1)) begin
            slot_wr[c] = '0;
          end else begin
            slot_wr[c].refs = slot_rd[c].refs - 1'b1;
          end
        end else begin
          if (!pick_ex_q[ev_idx_q]) begin
            slot_wr[c].ctype = priv_q ? TYPE_PRIVATE : TYPE_SHARED;
            if (priv_q) slot_wr[c].owner = owner_q;
          end
          if (slot_rd[c].refs != '1) slot_wr[c].refs = slot_rd[c].refs + 1'b1;
        end
      end
    end
    slot_we = ev_v_q && (((state_q == S_COMMIT) && picked_q[ev_idx_q])
                      || ((state_q == S_RELEASE) && color_mask_q[ev_idx_q]));
  end

  // busy and free count update
  always_comb begin
    cnt_wr   = cnt_rd;
    busy_sum = {1'b0, cnt_rd.busy} + (PCNT_W + 1)'(pcount_q);
    case (op_q)
      OP_BUSY_ADD:    cnt_wr.busy = busy_sum[PCNT_W] ? '1 : busy_sum[PCNT_W-1:0];
      OP_BUSY_REMOVE: cnt_wr.busy = (cnt_rd.busy < PCNT_W'(pcount_q)) ? '0
                                  : cnt_rd.busy - PCNT_W'(pcount_q);
      default:        cnt_wr.free = PCNT_W'(pcount_q);
    endcase
    cnt_we = state_q == S_CNT;
  end

  // sequencer
  always_comb begin
    state_d      = state_q;
    priv_d       = priv_q;
    cmask_d      = cmask_q;
    color_mask_d = color_mask_q;
    op_d         = op_q;
    cidx_d       = cidx_q;
    pcount_d     = pcount_q;
    owner_d      = owner_q;
    ncol_d       = ncol_q;
    ptr_d        = ptr_q;
    ev_v_d       = 1'b0;
    ev_idx_d     = ptr_q[COLOR_W-1:0];
    exist_v_d    = exist_v_q;
    fresh_v_d    = fresh_v_q;
    picked_d     = picked_q;
    pick_ex_d    = pick_ex_q;
    got_d        = got_q;
    phase_d      = phase_q;
    best_found_d = best_found_q;
    best_key_d   = best_key_q;
    best_idx_d   = best_idx_q;
    done_d       = 1'b0;
    status_d     = status_q;
    mask_d       = mask_q;
    div_start    = 1'b0;

    if (state_q != S_IDLE && state_q != S_DIVW && state_q != S_CNT) begin
      ev_v_d = issue;
      if (issue) ptr_d = ptr_q + 1'b1;
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d         = operation_i;
          priv_d       = operation_i == OP_RES_PRIVATE;
          cmask_d      = cache_mask_i[NUM_CACHES-1:0];
          color_mask_d = color_mask_i[NUM_COLORS-1:0];
          cidx_d       = color_index_i[COLOR_W-1:0];
          pcount_d     = page_count_i;
          owner_d      = owner_id_i;
          ptr_d        = '0;
          status_d     = ST_OK;
          mask_d       = '0;
          case (operation_i) inside
            OP_RES_SHARED, OP_RES_PRIVATE: begin
              if (ncol_full == '0) begin
                done_d   = 1'b1;
                status_d = ST_BAD_SIZE;
              end else if (cache_mask_i[NUM_CACHES-1:0] == '0
                           || ncol_full > NCOL_W'(NUM_COLORS)) begin
                done_d   = 1'b1;
                status_d = ST_NO_COLORS;
              end else begin
                div_start    = 1'b1;
                ncol_d       = ncol_full[PTR_W-1:0];
                exist_v_d    = '0;
                fresh_v_d    = '0;
                picked_d     = '0;
                pick_ex_d    = '0;
                got_d        = '0;
                phase_d      = !(use_free_q && operation_i == OP_RES_SHARED);
                best_found_d = 1'b0;
                state_d      = S_CLASS;
              end
            end
            OP_RELEASE: state_d = S_RELEASE;
            OP_BUSY_ADD, OP_BUSY_REMOVE, OP_SET_FREE: state_d = S_CNT;
            default: done_d = 1'b1;
          endcase
        end
      end
      S_CLASS: begin
        if (ev_v_q) begin
          if (priv_q) begin
            fresh_v_d[ev_idx_q] = all_free;
          end else if (use_free_q && all_shared) begin
            exist_v_d[ev_idx_q] = 1'b1;
          end else begin
            fresh_v_d[ev_idx_q] = none_private;
          end
        end
        if (pass_end) begin
          ptr_d   = '0;
          state_d = div_done ? S_ROUND : S_DIVW;
        end
      end
      S_DIVW: begin
        if (div_done) state_d = S_ROUND;
      end
      S_ROUND: begin
        if (ev_v_q && better) begin
          best_found_d = 1'b1;
          best_key_d   = key;
          best_idx_d   = ev_idx_q;
        end
        if (pass_end) begin
          ptr_d        = '0;
          best_found_d = 1'b0;
          if (best_found_q) begin
            picked_d[best_idx_q] = 1'b1;
            if (!phase_q) pick_ex_d[best_idx_q] = 1'b1;
            got_d = got_q + 1'b1;
            if (got_q + 1'b1 == ncol_q) state_d = S_COMMIT;
          end else if (!phase_q) begin
            phase_d = 1'b1;
          end else begin
            state_d  = S_IDLE;
            done_d   = 1'b1;
            status_d = ST_NO_COLORS;
          end
        end
      end
      S_COMMIT: begin
        if (pass_end) begin
          state_d  = S_IDLE;
          done_d   = 1'b1;
          status_d = ST_OK;
          mask_d   = MASK_W'(picked_q);
        end
      end
      S_RELEASE: begin
        if (pass_end) begin
          state_d = S_IDLE;
          done_d  = 1'b1;
        end
      end
      S_CNT: begin
        state_d = S_IDLE;
        done_d  = 1'b1;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      use_free_q   <= 1'b1;
      ptr_q        <= '0;
      ev_v_q       <= 1'b0;
      best_found_q <= 1'b0;
      done_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      ptr_q        <= ptr_d;
      ev_v_q       <= ev_v_d;
      best_found_q <= best_found_d;
      done_q       <= done_d;
      if (cfg_valid_i && cfg_ready_o) use_free_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    priv_q       <= priv_d;
    cmask_q      <= cmask_d;
    color_mask_q <= color_mask_d;
    op_q         <= op_d;
    cidx_q       <= cidx_d;
    pcount_q     <= pcount_d;
    owner_q      <= owner_d;
    ncol_q       <= ncol_d;
    ev_idx_q     <= ev_idx_d;
    exist_v_q    <= exist_v_d;
    fresh_v_q    <= fresh_v_d;
    picked_q     <= picked_d;
    pick_ex_q    <= pick_ex_d;
    got_q        <= got_d;
    phase_q      <= phase_d;
    best_key_q   <= best_key_d;
    best_idx_q   <= best_idx_d;
    status_q     <= status_d;
    mask_q       <= mask_d;
  end

  assign done_o        = done_q;
  assign status_o      = status_q;
  assign region_mask_o = mask_q;

endmodule

FILE: hdl/ccra_ram.sv
// generic one-write one-read synchronous ram with registered read data
// rows never written read as zero through per-row valid bits; no package use
module ccra_ram #(
  parameter int WIDTH  = 8,
  parameter int ADDR_W = 6
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i
);

  localparam int DEPTH = 1 << ADDR_W;

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [DEPTH-1:0] valid_q;
  logic [WIDTH-1:0] rdata_q;
  logic             rvalid_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      rvalid_q <= valid_q[raddr_i];
    end
  end

  assign rdata_o = rvalid_q ? rdata_q : '0;

endmodule

FILE: hdl/ccra_div.sv
// restoring divider, one quotient bit a cycle, result rounded up
// depends on ccra_pkg
module ccra_div import ccra_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [PAGES_W-1:0] dividend_i,
  input  logic [PTR_W-1:0]   divisor_i,
  output logic               done_o,
  output logic [PAGES_W-1:0] quot_o
);

  localparam int STEP_W = $clog2(PAGES_W + 1);

  logic [PAGES_W-1:0] quo_q, quo_d;
  logic [PTR_W:0]     rem_q, rem_d;
  logic [PTR_W-1:0]   div_q;
  logic [STEP_W-1:0]  step_q;
  logic               run_q, done_q;
  logic [PTR_W:0]     rem_sh;
  logic               ge;

  always_comb begin
    rem_sh = {rem_q[PTR_W-1:0], quo_q[PAGES_W-1]};
    ge     = rem_sh >= {1'b0, div_q};
    rem_d  = ge ? (rem_sh - {1'b0, div_q}) : rem_sh;
    quo_d  = {quo_q[PAGES_W-2:0], ge};
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (run_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      run_q  <= 1'b1;
      done_q <= 1'b0;
      step_q <= STEP_W'(PAGES_W);
    end else if (run_q) begin
      step_q <= step_q - 1'b1;
      if (step_q == STEP_W'(1)) begin
        run_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q + PAGES_W'(rem_q != '0);

endmodule

FILE: hdl/ccra_chk.sv
// port-level checker for the allocator and its bind
// depends on ccra_pkg and cache_color_reservation_allocator
module ccra_chk import ccra_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start,
  input logic                busy,
  input logic [OP_W-1:0]     operation_i,
  input logic [BYTES_W-1:0]  region_bytes_i,
  input logic                done_o,
  input logic [STATUS_W-1:0] status_o,
  input logic [MASK_W-1:0]   region_mask_o
);

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("result strobe while busy");

  a_fail_no_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != ST_OK) |-> region_mask_o == '0)
    else $error("failed item carries a color mask");

  a_update_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (operation_i == OP_RELEASE || operation_i == OP_BUSY_ADD
      || operation_i == OP_BUSY_REMOVE || operation_i == OP_SET_FREE)) |=> busy)
    else $error("table update did not go busy");

  a_zero_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (operation_i == OP_RES_SHARED || operation_i == OP_RES_PRIVATE)
      && region_bytes_i == '0) |=> (done_o && status_o == ST_BAD_SIZE))
    else $error("zero size reservation not rejected at once");

endmodule

bind cache_color_reservation_allocator ccra_chk u_ccra_chk (.*);

FILE: tb/cache_color_reservation_allocator_tb.sv
// testbench of the cache color reservation allocator: drives items and register writes,
// predicts each status and region mask with a scoreboard class; depends on ccra_pkg and the RTL
module cache_color_reservation_allocator_tb;
  import ccra_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // scoreboard: own copy of the color tables, predicts one result per accepted item
  class ccra_scoreboard;
    logic [1:0]         ctype [NUM_CACHES][NUM_COLORS];
    logic [OWNER_W-1:0] owner [NUM_CACHES][NUM_COLORS];
    logic [REF_W-1:0]   refs  [NUM_CACHES][NUM_COLORS];
    logic [PCNT_W-1:0]  busy_pg [NUM_COLORS];
    logic [PCNT_W-1:0]  free_pg [NUM_COLORS];
    bit                 rank_free;
    logic [STATUS_W-1:0] exp_status [$];
    logic [MASK_W-1:0]   exp_mask   [$];
    int                  errors;

    function void clear();
      for (int ca = 0; ca < NUM_CACHES; ca++)
        for (int co = 0; co < NUM_COLORS; co++) begin
          ctype[ca][co] = TYPE_FREE;
          owner[ca][co] = '0;
          refs[ca][co]  = '0;
        end
      for (int co = 0; co < NUM_COLORS; co++) begin
        busy_pg[co] = '0;
        free_pg[co] = '0;
      end
      rank_free = 1'b1;
      errors = 0;
    endfunction

    // stable insertion sort by the chosen count
    function void order_by(ref int lst[$], input bit by_free);
      int c, j;
      for (int i = 1; i < lst.size(); i++) begin
        c = lst[i];
        j = i - 1;
        while (j >= 0 && (by_free ? free_pg[lst[j]] > free_pg[c]
                                  : busy_pg[lst[j]] > busy_pg[c])) begin
          lst[j+1] = lst[j];
          j--;
        end
        lst[j+1] = c;
      end
    endfunction

    function int first_roomy(int lst[$], longint ppc);
      int i;
      for (i = 0; i < lst.size(); i++)
        if (longint'(free_pg[lst[i]]) >= ppc) break;
      return i;
    endfunction

    function void take(logic [3:0] cm, int co, bit set_t, logic [1:0] t, bit set_o,
                       logic [OWNER_W-1:0] ow);
      for (int ca = 0; ca < NUM_CACHES; ca++)
        if (cm[ca]) begin
          if (set_t) ctype[ca][co] = t;
          if (set_o) owner[ca][co] = ow;
          if (refs[ca][co] != 16'hFFFF) refs[ca][co]++;
        end
    endfunction

    function void reserve(logic [3:0] cm, bit priv, longint bytes, longint pages,
                          logic [OWNER_W-1:0] ow, output logic [1:0] st,
                          output logic [MASK_W-1:0] m);
      int shared_c[$], open_c[$];
      longint ncol, ppc, got;
      int ex_lo, ex_hi, nw_lo, nw_hi;
      bit all_sh, none_pr, all_fr;
      m = '0;
      ex_lo = 0; ex_hi = 0; nw_lo = 0; nw_hi = 0; got = 0;
      ncol = (bytes + BYTES_PER_COLOR - 1) / BYTES_PER_COLOR;
      if (ncol == 0) begin
        st = ST_BAD_SIZE;
        return;
      end
      ppc = (pages + ncol - 1) / ncol;
      if (cm == 0) begin
        st = ST_NO_COLORS;
        return;
      end
      for (int co = 0; co < NUM_COLORS; co++) begin
        all_sh = 1; none_pr = 1; all_fr = 1;
        for (int ca = 0; ca < NUM_CACHES; ca++)
          if (cm[ca]) begin
            if (ctype[ca][co] != TYPE_SHARED) all_sh = 0;
            if (ctype[ca][co] == TYPE_PRIVATE) none_pr = 0;
            if (ctype[ca][co] != TYPE_FREE) all_fr = 0;
          end
        if (priv) begin
          if (all_fr) open_c.push_back(co);
        end else if (rank_free && all_sh) shared_c.push_back(co);
        else if (none_pr) open_c.push_back(co);
      end
      if (rank_free) begin
        if (shared_c.size() > 0) begin
          order_by(shared_c, 1);
          ex_lo = first_roomy(shared_c, ppc);
          ex_hi = shared_c.size();
          if (ex_hi - ex_lo > ncol) ex_hi = ex_lo + int'(ncol);
          got = ex_hi - ex_lo;
        end
        if (got < ncol && open_c.size() > 0) begin
          order_by(open_c, 1);
          nw_lo = first_roomy(open_c, ppc);
          nw_hi = open_c.size();
          if (nw_hi - nw_lo > ncol - got) nw_hi = nw_lo + int'(ncol - got);
          got += nw_hi - nw_lo;
        end
      end else if (open_c.size() > 0) begin
        order_by(open_c, 0);
        nw_hi = open_c.size();
        if (nw_hi > ncol) nw_hi = int'(ncol);
        got = nw_hi;
      end
      if (got != ncol) begin
        st = ST_NO_COLORS;
        return;
      end
      for (int i = ex_lo; i < ex_hi; i++) begin
        take(cm, shared_c[i], 0, TYPE_FREE, 0, '0);
        m[shared_c[i]] = 1'b1;
      end
      for (int i = nw_lo; i < nw_hi; i++) begin
        if (priv) take(cm, open_c[i], 1, TYPE_PRIVATE, 1, ow);
        else      take(cm, open_c[i], 1, TYPE_SHARED, 0, '0);
        m[open_c[i]] = 1'b1;
      end
      st = ST_OK;
    endfunction

    // note an accepted item and queue its expected result
    function void note_item(logic [OP_W-1:0] op, logic [3:0] cm_in, logic [BYTES_W-1:0] by,
                            logic [PAGES_W-1:0] pg, logic [MASK_W-1:0] colors,
                            logic [5:0] idx, logic [PAGES_W-1:0] cnt,
                            logic [OWNER_W-1:0] ow);
      logic [1:0] st;
      logic [MASK_W-1:0] m;
      logic [3:0] cm;
      longint sum;
      cm = cm_in & 4'((1 << NUM_CACHES) - 1);
      st = ST_OK;
      m = '0;
      case (op)
        OP_RES_SHARED, OP_RES_PRIVATE: begin
          reserve(cm, op == OP_RES_PRIVATE, by, pg, ow, st, m);
        end
        OP_RELEASE: begin
          for (int co = 0; co < NUM_COLORS; co++)
            if (colors[co])
              for (int ca = 0; ca < NUM_CACHES; ca++)
                if (cm[ca]) begin
                  if (refs[ca][co] <= 1) begin
                    ctype[ca][co] = TYPE_FREE;
                    owner[ca][co] = '0;
                    refs[ca][co] = '0;
                  end else refs[ca][co]--;
                end
        end
        OP_BUSY_ADD: begin
          sum = longint'(busy_pg[idx]) + cnt;
          busy_pg[idx] = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
        end
        OP_BUSY_REMOVE: begin
          busy_pg[idx] = (busy_pg[idx] < cnt) ? '0 : busy_pg[idx] - cnt;
        end
        OP_SET_FREE: begin
          free_pg[idx] = cnt;
        end
        default: ;
      endcase
      exp_status.push_back(st);
      exp_mask.push_back(m);
    endfunction

    function void check_result(logic [STATUS_W-1:0] st, logic [MASK_W-1:0] m);
      if (exp_status.size() == 0) begin
        $error("unexpected result: status %0d region_mask %h", st, m);
        errors++;
        return;
      end
      if (st !== exp_status[0]) begin
        $error("status: expected %0d, actual %0d", exp_status[0], st);
        errors++;
      end
      if (m !== exp_mask[0]) begin
        $error("region_mask: expected %h, actual %h", exp_mask[0], m);
        errors++;
      end
      void'(exp_status.pop_front());
      void'(exp_mask.pop_front());
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic [OP_W-1:0]     operation_i = '0;
  logic [3:0]          cache_mask_i = '0;
  logic [BYTES_W-1:0]  region_bytes_i = '0;
  logic [PAGES_W-1:0]  page_total_i = '0;
  logic [MASK_W-1:0]   color_mask_i = '0;
  logic [5:0]          color_index_i = '0;
  logic [PAGES_W-1:0]  page_count_i = '0;
  logic [OWNER_W-1:0]  owner_id_i = '0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic                cfg_data_i = 1'b0;
  logic                done_o;
  logic [STATUS_W-1:0] status_o;
  logic [MASK_W-1:0]   region_mask_o;

  ccra_scoreboard colors_sb;
  int  idle_pct = 0;   // chance per cycle that the sender holds off
  int  quiet_cycles = 0;
  // limit with plenty of margin over the longest reservation
  localparam int QUIET_LIMIT = 40000;

  always #2 clk_i = ~clk_i;

  cache_color_reservation_allocator DUT (.*);

  // result checking at the rising edge; the receiver cannot stall
  always @(posedge clk_i) begin
    if (rst_ni && done_o) colors_sb.check_result(status_o, region_mask_o);
  end

  // watchdog: counts cycles in which neither an item, a register write nor a result moves
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o || (cfg_valid_i && cfg_ready_o)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("cache_color_reservation_allocator_tb: done, errors");
      $finish;
    end
  end

  // drive one item; holds start until accepted, fields change at the falling edge
  task automatic send_item(logic [OP_W-1:0] op, logic [3:0] cm, logic [BYTES_W-1:0] by,
                           logic [PAGES_W-1:0] pg, logic [MASK_W-1:0] colors,
                           logic [5:0] idx, logic [PAGES_W-1:0] cnt,
                           logic [OWNER_W-1:0] ow);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) @(negedge clk_i);
    operation_i <= op;
    cache_mask_i <= cm;
    region_bytes_i <= by;
    page_total_i <= pg;
    color_mask_i <= colors;
    color_index_i <= idx;
    page_count_i <= cnt;
    owner_id_i <= ow;
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
    colors_sb.note_item(op, cm, by, pg, colors, idx, cnt, ow);
    @(negedge clk_i);
    start <= 1'b0;
  endtask

  // wait for all results, let a last item settle, then write the ranking register
  task automatic drain();
    while (colors_sb.exp_status.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_rank(bit v);
    drain();
    cfg_data_i <= v;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    colors_sb.rank_free = v;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // random item; reservations (mostly small), releases of random colors, count updates and raw opcodes
  task automatic send_random();
    int kind;
    logic [BYTES_W-1:0] by;
    logic [MASK_W-1:0] cm64;
    logic [3:0] cm;
    logic [PAGES_W-1:0] pg, cnt;
    logic [5:0] idx;
    logic [OWNER_W-1:0] ow;
    kind = int'($urandom_range(99));
    cm64 = {$urandom, $urandom};
    cm = 4'($urandom);
    pg = PAGES_W'($urandom);
    cnt = PAGES_W'($urandom);
    idx = 6'($urandom);
    ow = OWNER_W'($urandom);
    if ($urandom_range(3) == 0) by = BYTES_W'($urandom);
    else by = BYTES_W'($urandom_range(4 * BYTES_PER_COLOR));
    if (kind < 30)
      send_item(OP_RES_SHARED, cm, by, pg, cm64, idx, cnt, ow);
    else if (kind < 45)
      send_item(OP_RES_PRIVATE, cm, by, pg, cm64, idx, cnt, ow);
    else if (kind < 60)
      send_item(OP_RELEASE, cm, by, pg, cm64, idx, cnt, ow);
    else if (kind < 70)
      send_item(OP_BUSY_ADD, cm, by, pg, cm64, idx,
                ($urandom_range(9) == 0) ? 20'hFFFFF : cnt, ow);
    else if (kind < 78)
      send_item(OP_BUSY_REMOVE, cm, by, pg, cm64, idx, cnt, ow);
    else if (kind < 96)
      send_item(OP_SET_FREE, cm, by, pg, cm64, idx,
                PAGES_W'($urandom_range(4096)), ow);
    else
      send_item(3'($urandom_range(7)), cm, by, pg, cm64, idx, cnt, ow);
  endtask

  initial begin
    colors_sb = new();
    colors_sb.clear();
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: zero size, empty mask, extremes, every operation
    send_item(OP_RES_SHARED, 4'hF, '0, '0, '0, '0, '0, '0);
    send_item(OP_RES_PRIVATE, 4'h0, 24'd1, '0, '0, '0, '0, '0);
    send_item(OP_RES_SHARED, 4'h1, 24'd1, 20'd5, '0, '0, '0, '0);     // no free pages yet
    send_item(OP_SET_FREE, 4'hF, '0, '0, '0, 6'd63, 20'hFFFFF, '0);
    send_item(OP_SET_FREE, 4'hF, '0, '0, '0, 6'd0, 20'd10, '0);
    send_item(OP_RES_SHARED, 4'h3, 24'd1, 20'd5, '0, '0, '0, '0);
    send_item(OP_RES_SHARED, 4'h3, 24'd1, 20'd5, '0, '0, '0, '0);     // reuses a shared color
    send_item(OP_RES_PRIVATE, 4'h4, 24'd65537, 20'hFFFFF, '0, '0, '0, 22'h3FFFFF);
    send_item(OP_RES_PRIVATE, 4'hF, 24'hFFFFFF, '0, '0, '0, '0, 22'h3FFFFF);
    send_item(OP_BUSY_ADD, '0, '0, '0, '0, 6'd5, 20'hFFFFF, '0);
    send_item(OP_BUSY_REMOVE, '0, '0, '0, '0, 6'd5, 20'hFFFFF, '0);
    send_item(OP_BUSY_REMOVE, '0, '0, '0, '0, 6'd5, 20'd1, '0);       // saturates at zero
    for (int i = 0; i < 4; i++)                                        // toward the 2^32-1 limit
      send_item(OP_BUSY_ADD, '0, '0, '0, '0, 6'd7, 20'hFFFFF, '0);
    send_item(OP_RELEASE, 4'h0, '0, '0, '1, '0, '0, '0);
    send_item(OP_RELEASE, 4'hF, '0, '0, '1, '0, '0, '0);
    send_item(3'd6, 4'hF, 24'hFFFFFF, 20'hFFFFF, '1, 6'd63, 20'hFFFFF, 22'h3FFFFF);
    send_item(3'd7, 4'hF, 24'd1, 20'd1, '1, 6'd1, 20'd1, 22'd1);

    write_rank(1'b0);
    send_item(OP_RES_SHARED, 4'hF, 24'(4 * BYTES_PER_COLOR), 20'd100, '0, '0, '0, '0);
    send_item(OP_RES_PRIVATE, 4'h8, 24'hFFFFFF, '0, '0, '0, '0, 22'h155555);
    send_item(OP_RELEASE, 4'hF, '0, '0, '1, '0, '0, '0);

    // random phases with varying sender idling and ranking mode
    for (int ph = 0; ph < 6; ph++) begin
      write_rank(ph[0]);
      case (ph % 3)
        0: idle_pct = 0;
        1: idle_pct = 64;
        default: idle_pct = 36;
      endcase
      repeat (190) send_random();
    end
    write_rank(1'b1);

    drain();
    if (colors_sb.errors == 0)
      $display("cache_color_reservation_allocator_tb: done, clean");
    else
      $display("cache_color_reservation_allocator_tb: done, errors");
    $finish;
  end
endmodule

FILE: files.f
hdl/ccra_pkg.sv
hdl/ccra_ram.sv
hdl/ccra_div.sv
hdl/cache_color_reservation_allocator.sv
hdl/ccra_chk.sv
tb/cache_color_reservation_allocator_tb.sv
